@@ hw/rtl/tkgs_pkg.sv @@
// tkgs_pkg: shared types, constants and helpers of the top-k gap select unit
// used by the channel interfaces, the ranking cell and the top level

package tkgs_pkg;

    localparam int MAX_REPORT  = 16;
    localparam int NUM_BINS    = 65536;
    localparam int DEPTH       = MAX_REPORT + 1;

    localparam int INDEX_W     = 16;
    localparam int COUNT_W     = 32;
    localparam int REPORT_W    = 5;
    localparam int POS_W       = $clog2(MAX_REPORT + 1);

    // contents of one ranking cell
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
    } cell_data_t;

    // what every cell does in the current cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } cell_op_t;

    // control broadcast from the top level to the chain
    typedef struct packed {
        cell_op_t           op;
        logic [INDEX_W-1:0] new_index;
        logic [COUNT_W-1:0] new_count;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // zero acts as one, values above the list size act as the list size
    function automatic logic [REPORT_W-1:0] clamp_report(input logic [REPORT_W-1:0] value);
        logic [REPORT_W-1:0] result;
        if (value == '0)
            result = REPORT_W'(1);
        else if (32'(value) > MAX_REPORT)
            result = REPORT_W'(MAX_REPORT);
        else
            result = value;
        return result;
    endfunction

    // bins at or beyond the histogram size are not ranked
    function automatic logic bin_in_range(input logic [INDEX_W-1:0] idx);
        return 32'(idx) < NUM_BINS;
    endfunction

endpackage

@@ hw/rtl/tkgs_bin_if.sv @@
// tkgs_bin_if: valid/ready channel carrying histogram bins
// depends on tkgs_pkg for field widths

interface tkgs_bin_if;
    import tkgs_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic               last_bin;

    modport source (output valid, output bin_index, output bin_count, output last_bin,
                    input ready);
    modport sink   (input valid, input bin_index, input bin_count, input last_bin,
                    output ready);
endinterface

@@ hw/rtl/tkgs_result_if.sv @@
// tkgs_result_if: valid/ready channel carrying ranked results
// depends on tkgs_pkg for field widths

interface tkgs_result_if;
    import tkgs_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] ranked_index;
    logic [COUNT_W-1:0] count_gap;
    logic               last_result;

    modport source (output valid, output ranked_index, output count_gap,
                    output last_result, input ready);
    modport sink   (input valid, input ranked_index, input count_gap,
                    input last_result, output ready);
endinterface

@@ hw/rtl/tkgs_cell.sv @@
// tkgs_cell: one rank of the insertion chain, holds a bin and its count
// depends on tkgs_pkg for cell_data_t and cell_ctrl_t

module tkgs_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tkgs_pkg::cell_ctrl_t ctrl,
    input  logic                 prev_keep,
    input  tkgs_pkg::cell_data_t prev_data,
    input  tkgs_pkg::cell_data_t next_data,
    output logic                 keep,
    output tkgs_pkg::cell_data_t data
);
    import tkgs_pkg::*;

    cell_data_t data_reg;
    cell_data_t data_next;

    // this cell ranks at or above the incoming bin (earlier arrival wins ties)
    assign keep = data_reg.valid && (data_reg.count >= ctrl.new_count);

    // insert, shift toward rank 0, or clear
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        data_next.valid = 1'b1;
                        data_next.index = ctrl.new_index;
                        data_next.count = ctrl.new_count;
                    end
                    else
                    begin
                        data_next = prev_data;
                    end
                end
            end
            CELL_SHIFT:
                data_next = next_data;
            CELL_CLEAR:
                data_next = '0;
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else
            data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/top_k_with_gap_select_unit.sv @@
// top_k_with_gap_select_unit: streaming top-k bin selection with count gaps
// depends on tkgs_pkg, tkgs_bin_if, tkgs_result_if and tkgs_cell
//
// channel     dir  fields                                  handshake
// bin_in      in   bin_index, bin_count, last_bin          valid/ready
// result_out  out  ranked_index, count_gap, last_result    valid/ready
// cfg         in   cfg_wr_data (report_count)              cfg_wr_en, no wait
//
// a bin is ranked in the cycle it is accepted: one bin per cycle while loading
// after a last bin the chain shifts toward rank 0, one result per cycle out of
// rank 0, and no bins are taken again until the whole set has been reported
// bin_in.ready is low during that emission; a stalled output holds the chain
// reset clears all cells, the output register and sets report_count to 1

module top_k_with_gap_select_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tkgs_pkg::REPORT_W-1:0]     cfg_wr_data,
    tkgs_bin_if.sink                          bin_in,
    tkgs_result_if.source                     result_out
);
    import tkgs_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [REPORT_W-1:0] report_count_reg;
    logic [POS_W-1:0]    emit_position_reg;
    logic [POS_W-1:0]    emit_position_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [COUNT_W-1:0]  out_gap_reg;
    logic                out_last_reg;

    cell_ctrl_t          ctrl;
    cell_data_t          cell_q [DEPTH];
    logic                keep   [DEPTH];
    logic [DEPTH-1:0]    valid_vec;

    logic [REPORT_W-1:0] k_eff;
    logic                accept;
    logic                load_result;
    logic                result_last;
    logic [COUNT_W-1:0]  next_count;

    assign k_eff  = clamp_report(report_count_reg);
    assign accept = bin_in.valid && bin_in.ready;
    assign bin_in.ready = (state_reg == ST_IDLE);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            report_count_reg <= REPORT_W'(1);
        else if (cfg_wr_en)
            report_count_reg <= cfg_wr_data;
    end

    // chain of ranking cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic       prev_keep;
        cell_data_t prev_data;
        cell_data_t next_data;

        if (i == 0)
        begin : g_head
            assign prev_keep = 1'b1;
            assign prev_data = '0;
        end
        else
        begin : g_body
            assign prev_keep = keep[i-1];
            assign prev_data = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_data = '0;
        end
        else
        begin : g_inner
            assign next_data = cell_q[i+1];
        end

        tkgs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .prev_keep (prev_keep),
            .prev_data (prev_data),
            .next_data (next_data),
            .keep      (keep[i]),
            .data      (cell_q[i])
        );

        assign valid_vec[i] = cell_q[i].valid;
    end

    // gap against the rank below, a missing rank counts as zero
    assign next_count  = cell_q[1].valid ? cell_q[1].count : '0;
    assign result_last = (32'(emit_position_reg) + 1 == 32'(k_eff)) || !cell_q[1].valid;

    // next state, chain control and output load
    always_comb
    begin
        state_next         = state_reg;
        emit_position_next = emit_position_reg;
        ctrl.op            = CELL_HOLD;
        ctrl.new_index     = bin_in.bin_index;
        ctrl.new_count     = bin_in.bin_count;
        load_result        = 1'b0;
        out_valid_next     = out_valid_reg && !result_out.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (bin_in_range(bin_in.bin_index))
                        ctrl.op = CELL_INSERT;
                    if (bin_in.last_bin)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!cell_q[0].valid)
                begin
                    // empty set: nothing to report
                    ctrl.op            = CELL_CLEAR;
                    emit_position_next = '0;
                    state_next         = ST_IDLE;
                end
                else if (!out_valid_reg || result_out.ready)
                begin
                    load_result    = 1'b1;
                    out_valid_next = 1'b1;
                    if (result_last)
                    begin
                        ctrl.op            = CELL_CLEAR;
                        emit_position_next = '0;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        ctrl.op            = CELL_SHIFT;
                        emit_position_next = emit_position_reg + POS_W'(1);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            emit_position_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            emit_position_reg <= emit_position_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_index_reg <= '0;
            out_gap_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else if (load_result)
        begin
            out_index_reg <= cell_q[0].index;
            out_gap_reg   <= cell_q[0].count - next_count;
            out_last_reg  <= result_last;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.ranked_index = out_index_reg;
    assign result_out.count_gap    = out_gap_reg;
    assign result_out.last_result  = out_last_reg;

    // no bins are taken while a set is reported
    a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !bin_in.ready)
        else $error("bin accepted during emission");

    // kept cells fill from rank 0 without holes
    a_cells_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + (DEPTH + 1)'(1)))
        else $error("hole in ranked list");

    // never more results than k in one set
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(emit_position_reg) < 32'(k_eff))
        else $error("emit position beyond report count");

    // the last result of a set ends the emission and empties the list
    a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        load_result && result_last |=> state_reg == ST_IDLE && valid_vec == '0)
        else $error("set not closed after last result");

endmodule

@@ test/top_k_with_gap_select_unit_tb.sv @@
// top_k_with_gap_select_unit_tb: self-checking testbench of the top-k gap select unit
// needs tkgs_pkg, tkgs_bin_if, tkgs_result_if and the unit itself; a directed table,
// then random histogram sets; results checked against the table or a ranking predictor
`timescale 1ns / 1ps

module top_k_with_gap_select_unit_tb;
    import tkgs_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 60;
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_CYCLES  = 80;

    // one reported rank as it leaves the unit
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] gap;
        logic               last;
    } ranked_bin_t;

    // one row of the directed table; top_* only used when typed is set
    typedef struct {
        int                 set_k;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        logic               last;
        bit                 typed;
        logic [INDEX_W-1:0] top_index;
        logic [COUNT_W-1:0] top_gap;
    } bin_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [REPORT_W-1:0] cfg_wr_data;

    tkgs_bin_if    bin_if ();
    tkgs_result_if res_if ();

    top_k_with_gap_select_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .bin_in      (bin_if),
        .result_out  (res_if)
    );

    // ranked list kept by the predictor
    logic [INDEX_W-1:0]  list_index [DEPTH];
    logic [COUNT_W-1:0]  list_count [DEPTH];
    logic                list_valid [DEPTH];
    logic [REPORT_W-1:0] report_k;

    ranked_bin_t ranked_batch [$];
    ranked_bin_t expected_ranks [$];
    bin_row_t    directed_rows [$];

    int errors        = 0;
    int stall_left    = 0;
    bit idle_en       = 1'b1;
    bit long_hold_req = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_list();
        for (int i = 0; i < DEPTH; i++)
        begin
            list_index[i] = '0;
            list_count[i] = '0;
            list_valid[i] = 1'b0;
        end
    endfunction

    // insert one bin into the ranked list; on a last bin fill ranked_batch with the top k
    function automatic void rank_bin(input logic [INDEX_W-1:0] idx,
                                     input logic [COUNT_W-1:0] cnt, input logic last);
        int                 pos;
        int                 kept;
        int                 k;
        int                 n;
        logic [COUNT_W-1:0] next_count;
        ranked_bin_t        item;
        ranked_batch.delete();
        if (32'(idx) < NUM_BINS)
        begin
            // equal counts stay above the newcomer
            pos = 0;
            while (pos < DEPTH && list_valid[pos] && list_count[pos] >= cnt)
                pos++;
            if (pos < DEPTH)
            begin
                for (int i = DEPTH - 1; i > pos; i--)
                begin
                    list_index[i] = list_index[i - 1];
                    list_count[i] = list_count[i - 1];
                    list_valid[i] = list_valid[i - 1];
                end
                list_index[pos] = idx;
                list_count[pos] = cnt;
                list_valid[pos] = 1'b1;
            end
        end
        if (last)
        begin
            k = int'(report_k);
            if (k < 1)
                k = 1;
            if (k > MAX_REPORT)
                k = MAX_REPORT;
            kept = 0;
            while (kept < DEPTH && list_valid[kept])
                kept++;
            n = (kept < k) ? kept : k;
            for (int r = 0; r < n; r++)
            begin
                next_count = (r + 1 < DEPTH && list_valid[r + 1]) ? list_count[r + 1] : '0;
                item.index = list_index[r];
                item.gap   = list_count[r] - next_count;
                item.last  = (r + 1 == n);
                ranked_batch.insert(ranked_batch.size(), item);
            end
            clear_list();
        end
    endfunction

    function automatic void add_row(input int set_k, input logic [INDEX_W-1:0] idx,
                                    input logic [COUNT_W-1:0] cnt, input logic last,
                                    input bit typed, input logic [INDEX_W-1:0] top_index,
                                    input logic [COUNT_W-1:0] top_gap);
        bin_row_t row;
        row.set_k     = set_k;
        row.index     = idx;
        row.count     = cnt;
        row.last      = last;
        row.typed     = typed;
        row.top_index = top_index;
        row.top_gap   = top_gap;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void report_error(input string msg);
        if (errors < 10)
            $display("mismatch: %s", msg);
        errors++;
    endfunction

    // offer one bin, with an optional idle burst first, and rank it once accepted
    task automatic send_bin(input logic [INDEX_W-1:0] idx, input logic [COUNT_W-1:0] cnt,
                            input logic last);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            bin_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bin_if.valid     <= 1'b1;
        bin_if.bin_index <= idx;
        bin_if.bin_count <= cnt;
        bin_if.last_bin  <= last;
        do
            @(posedge clk);
        while (!bin_if.ready);
        rank_bin(idx, cnt, last);
    endtask

    // write report_count once the unit has drained
    task automatic write_report_k(input logic [REPORT_W-1:0] value);
        bin_if.valid <= 1'b0;
        while (expected_ranks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        report_k = value;
    endtask

    // result side: check each transaction, then decide ready for the next cycle
    initial
    begin
        ranked_bin_t want;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                if (expected_ranks.size() == 0)
                    report_error($sformatf("unexpected result index %h gap %h last %b",
                                           res_if.ranked_index, res_if.count_gap,
                                           res_if.last_result));
                else
                begin
                    want = expected_ranks.pop_front();
                    if (res_if.ranked_index !== want.index || res_if.count_gap !== want.gap
                        || res_if.last_result !== want.last)
                        report_error($sformatf(
                            "expected index %h gap %h last %b, got index %h gap %h last %b",
                            want.index, want.gap, want.last, res_if.ranked_index,
                            res_if.count_gap, res_if.last_result));
                end
            end
            // stall bursts, and one long hold-off on request
            if (stall_left > 0)
                stall_left--;
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = HOLD_CYCLES;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
            res_if.ready <= (stall_left == 0);
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((bin_if.valid && bin_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("top_k_with_gap_select_unit_tb: done, errors");
        $finish;
    end

    // stimulus
    initial
    begin
        bin_row_t            row;
        ranked_bin_t         typed_top;
        int                  phase_items;
        int                  set_len;
        logic [REPORT_W-1:0] k_value;
        logic [INDEX_W-1:0]  idx_v;
        logic [COUNT_W-1:0]  cnt_v;

        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        bin_if.valid     <= 1'b0;
        bin_if.bin_index <= '0;
        bin_if.bin_count <= '0;
        bin_if.last_bin  <= 1'b0;
        clear_list();
        report_k = REPORT_W'(1);

        // k = 1 after reset: single bin, extremes, tie, zero count
        add_row(-1, 16'h0005, 32'd100, 1'b1, 1'b1, 16'h0005, 32'd100);
        add_row(-1, 16'h0000, 32'd0, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        add_row(-1, 16'h0007, 32'd50, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0009, 32'd50, 1'b1, 1'b1, 16'h0007, 32'd0);
        add_row(-1, 16'h8000, 32'd0, 1'b1, 1'b1, 16'h8000, 32'd0);
        // k = 16: fill all cells, then a tie with the lowest and a smaller bin are dropped
        add_row(16, 16'h0011, 32'd300, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0012, 32'd900, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0013, 32'd50, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0014, 32'd900, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0015, 32'd1200, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0016, 32'd10, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0017, 32'd700, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0018, 32'd450, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0019, 32'd450, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h001A, 32'd2000, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h001B, 32'd5, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h001C, 32'd800, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h001D, 32'd60, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h001E, 32'd330, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h001F, 32'd90, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0020, 32'd1500, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0021, 32'd25, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0100, 32'd5, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0101, 32'd1, 1'b0, 1'b0, '0, '0);
        add_row(-1, 16'h0102, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.set_k >= 0)
                write_report_k(REPORT_W'(row.set_k));
            send_bin(row.index, row.count, row.last);
            if (row.typed)
            begin
                typed_top.index = row.top_index;
                typed_top.gap   = row.top_gap;
                typed_top.last  = 1'b1;
                expected_ranks.insert(expected_ranks.size(), typed_top);
            end
            else
                foreach (ranked_batch[j])
                    expected_ranks.insert(expected_ranks.size(), ranked_batch[j]);
        end

        // random sets, one report_count setting per phase
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       k_value = REPORT_W'(0);
                1:       k_value = REPORT_W'(31);
                2:       k_value = REPORT_W'($urandom_range(2, 15));
                3:       k_value = REPORT_W'(17);
                4:       k_value = REPORT_W'(16);
                default: k_value = REPORT_W'($urandom_range(1, 31));
            endcase
            if (p == NUM_PHASES - 1)
                idle_en = 1'b0;
            write_report_k(k_value);
            if (p == 2)
                long_hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / NUM_PHASES + 1)
            begin
                // mostly short sets, some long enough to overflow the list
                set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 24)
                                                      : $urandom_range(1, 6);
                for (int j = 0; j < set_len; j++)
                begin
                    case ($urandom_range(0, 7))
                        0:       idx_v = '0;
                        1:       idx_v = '1;
                        default: idx_v = INDEX_W'($urandom_range(0, 65535));
                    endcase
                    // small counts give frequent ties
                    case ($urandom_range(0, 9))
                        0:       cnt_v = '0;
                        1:       cnt_v = '1;
                        2, 3:    cnt_v = COUNT_W'($urandom_range(0, 7));
                        default: cnt_v = $urandom;
                    endcase
                    send_bin(idx_v, cnt_v, j == set_len - 1);
                    foreach (ranked_batch[m])
                        expected_ranks.insert(expected_ranks.size(), ranked_batch[m]);
                end
                phase_items += set_len;
            end
        end

        // drain and finish
        bin_if.valid <= 1'b0;
        while (expected_ranks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("top_k_with_gap_select_unit_tb: done, clean");
        else
            $display("top_k_with_gap_select_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tkgs_pkg.sv
hw/rtl/tkgs_bin_if.sv
hw/rtl/tkgs_result_if.sv
hw/rtl/tkgs_cell.sv
hw/rtl/top_k_with_gap_select_unit.sv
test/top_k_with_gap_select_unit_tb.sv
